// ----- rtl/asw_pkg.sv -----
`timescale 1ns / 1ps
package asw_pkg;

  // request codes
  typedef enum logic [1:0] {
    OP_CHOOSE = 2'd0,
    OP_DONE   = 2'd1,
    OP_FAIL   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic REG_BACKEND_COUNT = 1'b0;
  localparam logic REG_LFSR_SEED     = 1'b1;

  localparam logic [15:0] SEED_DEFAULT = 16'd44257;
  localparam logic [15:0] LFSR_TAPS    = 16'hB400;

  typedef enum logic [4:0] {
    ST_FILL_LD,
    ST_FILL_DIV,
    ST_SWEEP,
    ST_IDLE,
    ST_WALK,
    ST_BEST,
    ST_DRAW,
    ST_MEAN,
    ST_MEAN2,
    ST_MUL,
    ST_MDIV_LD,
    ST_MDIV,
    ST_SUM,
    ST_ZFILL,
    ST_NRD,
    ST_NLD,
    ST_NDIV,
    ST_FRD,
    ST_FMUL,
    ST_FWR,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/adaptive_smooth_weighted_selector.sv -----
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Word
// req      in         req_valid/req_stall  operation, backend_index, answer_time_us
// rsp      out        rsp_valid/rsp_stall  chosen_backend, fell_back, tries_used
// cfg      in         wr_en                wr_index, wr_data
//
// A choose makes one credit walk per try, up to n-1 tries (n backends in use).
// A completion takes FB+1 multiply steps and up to n+1 divisions of 35+2*FB-bit dividends
// on the single shared serial divider, plus a sum walk; a failure skips all three.
// After reset and after each backend_count write, one division and a sweep of all
// MAX_BACKENDS table entries run while req_stall is high.
// One request is in work at a time; a finished word waits in the output register.
module adaptive_smooth_weighted_selector
  import asw_pkg::*;
#(
  parameter int MAX_BACKENDS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic        wr_index,
  input  logic [15:0] wr_data,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  operation,
  input  logic [3:0]  backend_index,
  input  logic [31:0] answer_time_us,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [3:0]  chosen_backend,
  output logic        fell_back,
  output logic [3:0]  tries_used
);

  localparam int FB    = FRACTION_BITS;
  localparam int N     = MAX_BACKENDS;
  localparam int AW    = $clog2(N);
  localparam int NW    = $clog2(N + 1);
  localparam int TW    = (NW > 4) ? NW : 4;
  localparam int XW    = (AW > 4) ? AW : 4;
  localparam int WW    = FB + 1;
  localparam int MW    = 32 + FB;
  localparam int DW    = 35 + 2 * FB;
  localparam int SW    = (33 + FB > 40) ? 33 + FB : 40;
  localparam int SUMW  = 40;
  localparam int KW    = $clog2(WW + 1);
  localparam int ALPHA_I = (99 * (2 ** FB) + 50) / 100;

  localparam logic [WW-1:0]  ONE        = {1'b1, {FB{1'b0}}};
  localparam logic [FB-1:0]  ALPHA      = FB'(ALPHA_I);
  localparam logic [FB-1:0]  BETA       = FB'((2 ** FB) - ALPHA_I);
  localparam logic [FB-1:0]  HALF       = FB'(2 ** (FB - 1));
  localparam logic [38:0]    W_CAP      = 39'h40_0000_0000;
  localparam logic [MW-1:0]  MEAN_RESET = MW'(64'd1000000 << FB);
  localparam logic [MW-1:0]  MEAN_MAX   = {MW{1'b1}};

  state_t state, state_next;

  logic [4:0]          backend_count;
  logic [15:0]         lfsr;
  logic [MW-1:0]       mean;
  logic                clr_fail;
  logic [WW-1:0]       fill;
  op_t                 op;
  logic [3:0]          idx;
  logic [31:0]         t;
  logic [NW-1:0]       i;
  logic                pv;
  logic [AW-1:0]       paddr;
  logic [AW-1:0]       best;
  logic signed [31:0]  cmax;
  logic [TW-1:0]       tries;
  logic [3:0]          res_chosen;
  logic                res_fell;
  logic [3:0]          res_tries;
  logic [32+FB-1:0]    ph;
  logic [2*FB-1:0]     pl;
  logic [32+FB-1:0]    pt;
  logic [MW:0]         mb;
  logic [MW:0]         divc;
  logic [DW-1:0]       acc;
  logic [WW-1:0]       wsh;
  logic [KW-1:0]       k;
  logic [38:0]         wnew;
  logic [SUMW-1:0]     sum;
  logic [2*FB-1:0]     fp;

  logic [NW-1:0]       n_act;
  logic                accept;
  logic                out_free;
  logic                req_in_range;
  logic [AW-1:0]       idx_a;
  logic [AW-1:0]       req_a;

  // table ports
  logic                w_we, c_we, f_we;
  logic [AW-1:0]       w_waddr, c_waddr, f_waddr;
  logic [AW-1:0]       w_raddr, c_raddr, f_raddr;
  logic [WW-1:0]       w_wdata, w_rd;
  logic [31:0]         c_wdata, c_rd;
  logic [FB-1:0]       f_wdata, f_rd;

  // divider
  logic                div_start, div_busy, div_done;
  logic [DW-1:0]       div_a, div_q;
  logic [SW-1:0]       div_b;

  // datapath terms
  logic signed [31:0]  walk_new;
  logic signed [31:0]  best_dec;
  logic [15:0]         lfsr_next;
  logic [16+FB-1:0]    draw_val;
  logic [FB-1:0]       fr;
  logic                got;
  logic [TW-1:0]       tries_inc;
  logic                last_try;
  logic [XW-1:0]       best_x;
  logic [MW+1:0]       nw_raw;
  logic [MW-1:0]       nw_sat;
  logic [38:0]         wsum_p;
  logic [38:0]         wsub_i;
  logic [FB:0]         fsum;
  logic [FB-1:0]       fx;

  function automatic logic [31:0] sat32(input logic [33:0] s);
    logic [31:0] r;
    if (!s[33] && (s[32] || s[31])) begin
      r = 32'h7FFF_FFFF;
    end else if (s[33] && !(s[32] && s[31])) begin
      r = 32'h8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  asw_ram #(.WIDTH(WW), .DEPTH(N)) u_weight (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(w_raddr), .rdata(w_rd)
  );

  asw_ram #(.WIDTH(32), .DEPTH(N)) u_credit (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata), .raddr(c_raddr), .rdata(c_rd)
  );

  asw_ram #(.WIDTH(FB), .DEPTH(N)) u_fail (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(f_raddr), .rdata(f_rd)
  );

  asw_div #(.DW(DW), .SW(SW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  // backends in use
  always_comb begin
    if (backend_count == 5'd0) begin
      n_act = NW'(1);
    end else if (int'(backend_count) > N) begin
      n_act = NW'(N);
    end else begin
      n_act = NW'(backend_count);
    end
  end

  assign req_stall    = (state != ST_IDLE);
  assign accept       = req_valid && !req_stall;
  assign out_free     = !rsp_valid || !rsp_stall;
  assign req_in_range = (32'(backend_index) < 32'(n_act));
  assign idx_a        = AW'(idx);
  assign req_a        = AW'(backend_index);

  // credit walk and draw
  always_comb begin
    walk_new  = $signed(sat32(34'($signed(c_rd)) + 34'(w_rd)));
    best_dec  = $signed(sat32(34'(cmax) - 34'(ONE)));
    lfsr_next = (lfsr >> 1) ^ (lfsr[0] ? LFSR_TAPS : 16'd0);
    draw_val  = {lfsr_next, {FB{1'b0}}} >> 16;
    fr        = (f_rd > ALPHA) ? ALPHA : f_rd;
    got       = (draw_val >= (16+FB)'(fr));
    tries_inc = tries + TW'(1);
    last_try  = (tries_inc == TW'(n_act) - TW'(1));
    best_x    = XW'(best);
  end

  // moving averages and weight terms
  always_comb begin
    nw_raw = (MW+2)'(ph) + (MW+2)'(((2*FB+1)'(pl) + (2*FB+1)'(HALF)) >> FB) + (MW+2)'(pt);
    nw_sat = (nw_raw > (MW+2)'(MEAN_MAX)) ? MEAN_MAX : nw_raw[MW-1:0];
    wsum_p = (paddr == idx_a) ? wnew : 39'(w_rd);
    wsub_i = (i[AW-1:0] == idx_a) ? wnew : 39'(w_rd);
    fsum   = (FB+1)'(((2*FB+1)'(fp) + (2*FB+1)'(HALF)) >> FB)
           + ((op == OP_FAIL) ? (FB+1)'(BETA) : (FB+1)'(0));
    fx     = fsum[FB] ? {FB{1'b1}} : fsum[FB-1:0];
  end

  // divider operands
  always_comb begin
    if (state == ST_MDIV_LD) begin
      div_a = acc + DW'(divc >> 1);
      div_b = SW'(divc);
    end else if (state == ST_NLD) begin
      div_a = (DW'(wsub_i) << FB) + DW'(sum >> 1);
      div_b = SW'(sum);
    end else begin
      div_a = DW'(ONE);
      div_b = SW'(n_act);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (wr_en && wr_index == REG_BACKEND_COUNT) begin
      state_next = ST_FILL_LD;
    end else begin
      unique case (state)
        ST_FILL_LD:  state_next = ST_FILL_DIV;
        ST_FILL_DIV: if (div_done) state_next = ST_SWEEP;
        ST_SWEEP:    if (i == NW'(N - 1)) state_next = ST_IDLE;
        ST_IDLE: begin
          if (accept) begin
            unique case (op_t'(operation))
              OP_CHOOSE: state_next = (n_act == NW'(1)) ? ST_DONE : ST_WALK;
              OP_DONE:   state_next = req_in_range ? ST_MEAN : ST_DONE;
              OP_FAIL:   state_next = req_in_range ? ST_FRD : ST_DONE;
              default:   state_next = ST_DONE;
            endcase
          end
        end
        ST_WALK:     if (i == n_act && !pv) state_next = ST_BEST;
        ST_BEST:     state_next = ST_DRAW;
        ST_DRAW:     state_next = (got || last_try) ? ST_DONE : ST_WALK;
        ST_MEAN:     state_next = ST_MEAN2;
        ST_MEAN2:    state_next = ST_MUL;
        ST_MUL:      if (k == KW'(WW - 1)) state_next = ST_MDIV_LD;
        ST_MDIV_LD:  state_next = ST_MDIV;
        ST_MDIV:     if (div_done) state_next = ST_SUM;
        ST_SUM: begin
          if (i == n_act && !pv) begin
            state_next = (sum == '0) ? ST_ZFILL : ST_NRD;
          end
        end
        ST_ZFILL:    if (i == n_act - NW'(1)) state_next = ST_FRD;
        ST_NRD:      state_next = (i == n_act) ? ST_FRD : ST_NLD;
        ST_NLD:      state_next = ST_NDIV;
        ST_NDIV:     if (div_done) state_next = ST_NRD;
        ST_FRD:      state_next = ST_FMUL;
        ST_FMUL:     state_next = ST_FWR;
        ST_FWR:      state_next = ST_DONE;
        ST_DONE:     if (out_free) state_next = ST_IDLE;
        default:     state_next = ST_IDLE;
      endcase
    end
  end

  // table and divider control
  always_comb begin
    w_we      = 1'b0;
    w_waddr   = i[AW-1:0];
    w_wdata   = fill;
    w_raddr   = idx_a;
    c_we      = 1'b0;
    c_waddr   = paddr;
    c_wdata   = walk_new;
    c_raddr   = i[AW-1:0];
    f_we      = 1'b0;
    f_waddr   = idx_a;
    f_wdata   = fx;
    f_raddr   = idx_a;
    div_start = 1'b0;
    unique case (state)
      ST_FILL_LD: div_start = 1'b1;
      ST_SWEEP: begin
        w_we    = 1'b1;
        c_we    = 1'b1;
        c_waddr = i[AW-1:0];
        c_wdata = '0;
        f_we    = clr_fail;
        f_waddr = i[AW-1:0];
        f_wdata = '0;
      end
      ST_WALK: begin
        w_raddr = i[AW-1:0];
        c_we    = pv;
      end
      ST_BEST: begin
        c_we    = 1'b1;
        c_waddr = best;
        c_wdata = best_dec;
        f_raddr = best;
      end
      ST_MDIV_LD: div_start = 1'b1;
      ST_SUM:     w_raddr = i[AW-1:0];
      ST_ZFILL:   w_we = 1'b1;
      ST_NRD:     w_raddr = i[AW-1:0];
      ST_NLD: begin
        w_raddr   = i[AW-1:0];
        div_start = 1'b1;
      end
      ST_NDIV: begin
        w_raddr = i[AW-1:0];
        w_we    = div_done;
        w_wdata = div_q[WW-1:0];
      end
      ST_FWR:     f_we = 1'b1;
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_FILL_LD;
      backend_count <= 5'd1;
      lfsr          <= SEED_DEFAULT;
      mean          <= MEAN_RESET;
      clr_fail      <= 1'b1;
      rsp_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (state == ST_SWEEP && i == NW'(N - 1)) begin
        clr_fail <= 1'b0;
      end
      if (state == ST_DRAW) begin
        lfsr <= lfsr_next;
      end
      if (state == ST_MEAN2) begin
        mean <= nw_sat;
      end
      if (wr_en) begin
        unique case (wr_index)
          REG_BACKEND_COUNT: backend_count <= wr_data[4:0];
          REG_LFSR_SEED:     lfsr <= (wr_data != 16'd0) ? wr_data : SEED_DEFAULT;
          default: begin
          end
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_FILL_LD: i <= '0;
      ST_FILL_DIV: begin
        if (div_done) fill <= div_q[WW-1:0];
        i <= '0;
      end
      ST_SWEEP: i <= i + NW'(1);
      ST_IDLE: begin
        if (accept) begin
          op         <= op_t'(operation);
          idx        <= backend_index;
          t          <= answer_time_us;
          res_tries  <= 4'd0;
          // a choose starts as the fall-back word, the unused code as all zero
          res_fell   <= (op_t'(operation) == OP_CHOOSE);
          res_chosen <= (op_t'(operation) == OP_NONE || op_t'(operation) == OP_CHOOSE)
                        ? 4'd0 : backend_index;
          i     <= '0;
          pv    <= 1'b0;
          tries <= '0;
        end
      end
      ST_WALK: begin
        if (i < n_act) i <= i + NW'(1);
        pv    <= (i < n_act);
        paddr <= i[AW-1:0];
        if (pv && (paddr == '0 || walk_new > cmax)) begin
          cmax <= walk_new;
          best <= paddr;
        end
      end
      ST_DRAW: begin
        tries      <= tries_inc;
        res_chosen <= got ? best_x[3:0] : 4'd0;
        res_fell   <= !got;
        res_tries  <= tries_inc[3:0];
        i          <= '0;
        pv         <= 1'b0;
      end
      ST_MEAN: begin
        ph <= mean[MW-1:FB] * ALPHA;
        pl <= mean[FB-1:0] * ALPHA;
        pt <= t * BETA;
      end
      ST_MEAN2: begin
        mb   <= (MW+1)'(mean) + (MW+1)'(ONE);
        divc <= (MW+1)'(nw_sat) + (MW+1)'(ONE);
        wsh  <= w_rd;
        acc  <= '0;
        k    <= '0;
      end
      ST_MUL: begin
        acc <= (acc << 1) + (wsh[WW-1] ? DW'(mb) : DW'(0));
        wsh <= wsh << 1;
        k   <= k + KW'(1);
      end
      ST_MDIV: begin
        if (div_done) begin
          wnew <= (div_q > DW'(W_CAP)) ? W_CAP : div_q[38:0];
          i    <= '0;
          pv   <= 1'b0;
          sum  <= '0;
        end
      end
      ST_SUM: begin
        if (i < n_act) begin
          i <= i + NW'(1);
        end else if (!pv) begin
          i <= '0;
        end
        pv    <= (i < n_act);
        paddr <= i[AW-1:0];
        if (pv) sum <= sum + SUMW'(wsum_p);
      end
      ST_ZFILL: i <= i + NW'(1);
      ST_NDIV:  if (div_done) i <= i + NW'(1);
      ST_FMUL:  fp <= f_rd * ALPHA;
      ST_DONE: begin
        if (out_free) begin
          chosen_backend <= res_chosen;
          fell_back      <= res_fell;
          tries_used     <= res_tries;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_fell_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && fell_back) |-> (chosen_backend == 4'd0))
    else $error("fall-back word names a backend other than zero");

  a_lfsr_live: assert property (@(posedge clk) disable iff (rst)
    lfsr != 16'd0)
    else $error("draw register stuck at zero");

  a_word_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_free) |=> rsp_valid)
    else $error("finished word not presented");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");
`endif

endmodule

// ----- rtl/asw_ram.sv -----
`timescale 1ns / 1ps
module asw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/asw_div.sv -----
`timescale 1ns / 1ps
module asw_div #(
  parameter int DW = 67,
  parameter int SW = 49
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CNTW = $clog2(DW + 1);

  logic [SW:0]     rem;
  logic [DW-1:0]   quo;
  logic [SW-1:0]   dv;
  logic [CNTW-1:0] cnt;
  logic [SW:0]     shifted;
  logic [SW:0]     diff;
  logic            ge;

  // one restoring step per cycle while busy
  always_comb begin
    shifted = {rem[SW-1:0], quo[DW-1]};
    diff    = shifted - {1'b0, dv};
    ge      = (shifted >= {1'b0, dv});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        quo  <= dividend;
        dv   <= divisor;
        cnt  <= CNTW'(DW);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff : shifted;
        quo <= {quo[DW-2:0], ge};
        cnt <= cnt - CNTW'(1);
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import asw_pkg::*;

  localparam longint unsigned ONE       = 64'd1 << 16;
  localparam longint unsigned ALPHA     = (64'd99 * ONE + 64'd50) / 64'd100;
  localparam longint unsigned BETA      = ONE - ALPHA;
  localparam longint unsigned MEAN_CEIL = (64'd1 << 48) - 64'd1;
  localparam longint unsigned W_CAP     = 64'd1 << 38;
  localparam longint          CR_MAX    = 64'sd2147483647;
  localparam longint          CR_MIN    = -64'sd2147483648;

  typedef struct packed {
    logic [3:0] backend;
    logic       fell;
    logic [3:0] tries;
  } pick_word_t;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic        wr_index;
  logic [15:0] wr_data;
  logic        req_valid;
  logic        req_stall;
  logic [1:0]  operation;
  logic [3:0]  backend_index;
  logic [31:0] answer_time_us;
  logic        rsp_valid;
  logic        rsp_stall;
  logic [3:0]  chosen_backend;
  logic        fell_back;
  logic [3:0]  tries_used;

  adaptive_smooth_weighted_selector u_top (.*);

  // selector state as predicted
  longint unsigned weight_q[16];
  longint          credit_q[16];
  longint unsigned fail_avg[16];
  longint unsigned mean_time;
  logic [15:0]     draw_reg;
  logic [4:0]      count_reg;

  pick_word_t pending_picks[$];
  int         errors;
  bit         quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("** adaptive_smooth_weighted_selector: FAILED **");
    $finish;
  end

  function automatic int unsigned in_use();
    if (count_reg == 5'd0) return 1;
    if (count_reg > 5'd16) return 16;
    return count_reg;
  endfunction

  function automatic longint unsigned q_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = 128'(a) * 128'(b) + 128'(ONE >> 1);
    return 64'(p >> 16);
  endfunction

  function automatic longint unsigned scale_div(longint unsigned a, longint unsigned b,
                                                longint unsigned c);
    logic [127:0] p;
    p = (128'(a) * 128'(b) + 128'(c >> 1)) / 128'(c);
    if (p >= (128'd1 << 63)) return 64'h7FFF_FFFF_FFFF_FFFF;
    return 64'(p);
  endfunction

  function automatic longint unsigned ema(longint unsigned m, longint unsigned x);
    return q_mul(m, ALPHA) + q_mul(x, BETA);
  endfunction

  function automatic longint sat_credit(longint c, longint d);
    longint s;
    s = c + d;
    if (s > CR_MAX) return CR_MAX;
    if (s < CR_MIN) return CR_MIN;
    return s;
  endfunction

  function automatic void even_weights();
    for (int i = 0; i < 16; i++) weight_q[i] = ONE / in_use();
  endfunction

  // one Galois LFSR step, draw scaled to the fraction width
  function automatic longint unsigned next_draw();
    logic lsb;
    lsb = draw_reg[0];
    draw_reg = draw_reg >> 1;
    if (lsb) draw_reg = draw_reg ^ LFSR_TAPS;
    return 64'(draw_reg);
  endfunction

  function automatic int unsigned credit_pick();
    int unsigned best;
    longint top;
    best = 0;
    top = 0;
    for (int i = 0; i < in_use(); i++) begin
      credit_q[i] = sat_credit(credit_q[i], longint'(weight_q[i]));
      if (i == 0 || credit_q[i] > top) begin
        top = credit_q[i];
        best = i;
      end
    end
    credit_q[best] = sat_credit(credit_q[best], -longint'(ONE));
    return best;
  endfunction

  function automatic void renormalise();
    longint unsigned total;
    total = 0;
    for (int i = 0; i < in_use(); i++) total += weight_q[i];
    for (int i = 0; i < in_use(); i++)
      if (total == 0) weight_q[i] = ONE / in_use();
      else weight_q[i] = (weight_q[i] * ONE + (total >> 1)) / total;
  endfunction

  function automatic pick_word_t select_backend(op_t op, logic [3:0] idx, logic [31:0] t);
    pick_word_t w;
    int unsigned left, tries, chosen;
    bit got;
    longint unsigned cap, d, prev, nxt, x;
    w = '0;
    if (op == OP_CHOOSE) begin
      left = in_use() - 1;
      tries = 0;
      chosen = 0;
      got = 0;
      while (!got && left > 0) begin
        left--;
        tries++;
        chosen = credit_pick();
        cap = fail_avg[chosen];
        if (cap > ALPHA) cap = ALPHA;
        d = next_draw();
        got = !(d < cap);
      end
      w.backend = got ? 4'(chosen) : 4'd0;
      w.fell = !got;
      w.tries = 4'(tries);
    end else if (op == OP_DONE || op == OP_FAIL) begin
      w.backend = idx;
      if (idx < in_use()) begin
        x = 0;
        if (op == OP_DONE) begin
          prev = mean_time;
          nxt = ema(prev, 64'(t) << 16);
          if (nxt > MEAN_CEIL) nxt = MEAN_CEIL;
          mean_time = nxt;
          weight_q[idx] = scale_div(weight_q[idx], prev + ONE, nxt + ONE);
          if (weight_q[idx] > W_CAP) weight_q[idx] = W_CAP;
          renormalise();
        end else begin
          x = ONE;
        end
        x = ema(fail_avg[idx], x);
        if (x > ONE - 1) x = ONE - 1;
        fail_avg[idx] = x;
      end
    end
    return w;
  endfunction

  // result checker
  always @(posedge clk) begin
    pick_word_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_picks.size() == 0) begin
        $display("%t unexpected word: backend %0d fell %0b tries %0d", $realtime,
                 chosen_backend, fell_back, tries_used);
        errors++;
      end else begin
        e = pending_picks.pop_front();
        if (chosen_backend !== e.backend) begin
          $display("%t chosen_backend expected %0d actual %0d", $realtime, e.backend,
                   chosen_backend);
          errors++;
        end
        if (fell_back !== e.fell) begin
          $display("%t fell_back expected %0b actual %0b", $realtime, e.fell, fell_back);
          errors++;
        end
        if (tries_used !== e.tries) begin
          $display("%t tries_used expected %0d actual %0d", $realtime, e.tries,
                   tries_used);
          errors++;
        end
      end
    end
  end

  // receiver back-pressure in bursts
  initial begin
    int k;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        k = $urandom_range(1, 9);
        repeat (k) begin
          rsp_stall = 1'b1;
          @(negedge clk);
        end
      end
      rsp_stall = 1'b0;
    end
  end

  task automatic send_word(op_t op, logic [3:0] idx, logic [31:0] t);
    int k;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      k = $urandom_range(1, 9);
      req_valid = 1'b0;
      repeat (k) @(negedge clk);
    end
    req_valid = 1'b1;
    operation = op;
    backend_index = idx;
    answer_time_us = t;
    forever begin
      @(posedge clk);
      if (!req_stall) break;
    end
    pending_picks.push_back(select_backend(op, idx, t));
  endtask

  task automatic drain();
    @(negedge clk);
    req_valid = 1'b0;
    while (pending_picks.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    @(negedge clk);
    wr_en = 1'b0;
    if (idx == REG_BACKEND_COUNT) begin
      count_reg = val[4:0];
      even_weights();
      for (int i = 0; i < 16; i++) credit_q[i] = 0;
    end else begin
      draw_reg = (val == 16'd0) ? SEED_DEFAULT : val;
    end
  endtask

  // a single backend, the unused code and events out of range
  task automatic test_single_backend();
    send_word(OP_CHOOSE, 4'd0, 32'd0);
    send_word(OP_NONE, 4'd15, 32'hFFFF_FFFF);
    send_word(OP_DONE, 4'd0, 32'd0);
    send_word(OP_FAIL, 4'd0, 32'd0);
    send_word(OP_DONE, 4'd5, 32'd1000);
    send_word(OP_CHOOSE, 4'd0, 32'd0);
  endtask

  // all backends, then counts below and above the legal range
  task automatic test_count_extremes();
    write_reg(REG_BACKEND_COUNT, 16'd16);
    send_word(OP_CHOOSE, 4'd0, 32'd0);
    send_word(OP_DONE, 4'd15, 32'hFFFF_FFFF);
    send_word(OP_FAIL, 4'd15, 32'd0);
    send_word(OP_DONE, 4'd0, 32'd0);
    send_word(OP_CHOOSE, 4'd0, 32'd0);
    write_reg(REG_BACKEND_COUNT, 16'd0);
    send_word(OP_CHOOSE, 4'd0, 32'd0);
    send_word(OP_DONE, 4'd1, 32'd5);
    write_reg(REG_BACKEND_COUNT, 16'd31);
    send_word(OP_CHOOSE, 4'd0, 32'd0);
    send_word(OP_FAIL, 4'd3, 32'd0);
  endtask

  // seed loads, the zero seed falling back to the default
  task automatic test_seed_loads();
    write_reg(REG_LFSR_SEED, 16'd0);
    write_reg(REG_BACKEND_COUNT, 16'd2);
    repeat (4) send_word(OP_FAIL, 4'd1, 32'd0);
    send_word(OP_CHOOSE, 4'd0, 32'd0);
    write_reg(REG_LFSR_SEED, 16'hFFFF);
    send_word(OP_CHOOSE, 4'd0, 32'd0);
    write_reg(REG_LFSR_SEED, 16'd1);
    send_word(OP_CHOOSE, 4'd0, 32'd0);
  endtask

  // random traffic over a series of settings, the last without idling
  task automatic test_random_traffic();
    int unsigned cnt, r, n;
    int hot;
    logic [3:0] idx;
    logic [31:0] t;
    op_t op;
    for (int ph = 0; ph < 11; ph++) begin
      r = $urandom_range(0, 9);
      if (r == 0) cnt = $urandom_range(17, 31);
      else if (r == 1) cnt = $urandom_range(0, 1);
      else cnt = $urandom_range(2, 16);
      if (ph == 9) cnt = 16;
      write_reg(REG_BACKEND_COUNT, 16'(cnt) | (16'($urandom_range(0, 2047)) << 5));
      if ($urandom_range(0, 1)) write_reg(REG_LFSR_SEED, 16'($urandom));
      if (ph == 10) quiet = 1;
      n = in_use();
      hot = $urandom_range(0, n - 1);
      for (int k = 0; k < 150; k++) begin
        r = $urandom_range(0, 99);
        if (r < 50) op = OP_CHOOSE;
        else if (r < 72) op = OP_DONE;
        else if (r < 96) op = OP_FAIL;
        else op = OP_NONE;
        if ($urandom_range(0, 9) == 0) idx = 4'($urandom);
        else if (op == OP_FAIL && $urandom_range(0, 1)) idx = 4'(hot);
        else idx = 4'($urandom_range(0, n - 1));
        r = $urandom_range(0, 9);
        if (r == 0) t = $urandom;
        else if (r == 1) t = 32'($urandom_range(0, 3));
        else t = 32'($urandom_range(0, 3000000));
        send_word(op, idx, t);
      end
    end
  endtask

  initial begin
    errors = 0;
    quiet = 0;
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = 1'b0;
    wr_data = '0;
    req_valid = 1'b0;
    operation = '0;
    backend_index = '0;
    answer_time_us = '0;
    count_reg = 5'd1;
    draw_reg = SEED_DEFAULT;
    mean_time = 64'd1000000 << 16;
    for (int i = 0; i < 16; i++) begin
      credit_q[i] = 0;
      fail_avg[i] = 0;
    end
    even_weights();
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_single_backend();
    test_count_extremes();
    test_seed_loads();
    test_random_traffic();

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("** adaptive_smooth_weighted_selector: PASSED **");
    else $display("** adaptive_smooth_weighted_selector: FAILED **");
    $finish;
  end

endmodule

// ----- adaptive_smooth_weighted_selector.f -----
rtl/asw_pkg.sv
rtl/asw_ram.sv
rtl/asw_div.sv
rtl/adaptive_smooth_weighted_selector.sv
sim/tb.sv
